@@ hdl/fbd_pkg.sv @@
// fbd_pkg: shared widths, constants, tables and helper functions for the
// fractional baud divisor encoder; no dependencies
`timescale 1ns / 1ps

package fbd_pkg;

  localparam int unsigned REF_CLOCK_HZ_DEF = 24000000;

  localparam int unsigned BAUD_W = 24;
  localparam int unsigned DIV_W  = 17;
  localparam int unsigned TRY_W  = 28;
  localparam int unsigned RATE_W = 22;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHIP_W = 3;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned ENC_W  = 17;

  localparam logic [DIV_W-1:0] AM_MAX_DIV     = 17'h1FFF8;
  localparam logic [DIV_W-1:0] BM_MAX_DIV     = 17'h1FFFF;
  localparam logic [ENC_W-1:0] ENC_SPECIAL_2M = 17'h04001;

  localparam logic [CHIP_W-1:0] CHIP_AM     = 3'd0;
  localparam logic [CHIP_W-1:0] CHIP_DUAL_C = 3'd2;
  localparam logic [CHIP_W-1:0] CHIP_DUAL_H = 3'd4;
  localparam logic [CHIP_W-1:0] CHIP_QUAD_H = 3'd5;

  typedef enum logic {
    REG_CHIP_TYPE = 1'b0,
    REG_CHANNEL   = 1'b1
  } reg_idx_e;

  function automatic logic [2:0] am_round_up(input logic [2:0] f);
    logic [2:0] r;
    unique case (f)
      3'd3:    r = 3'd1;
      3'd5:    r = 3'd3;
      3'd6:    r = 3'd2;
      3'd7:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] am_round_down(input logic [2:0] f);
    logic [2:0] r;
    unique case (f)
      3'd3:    r = 3'd1;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd2;
      3'd7:    r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] fraction_code(input logic [2:0] f);
    logic [2:0] r;
    unique case (f)
      3'd0: r = 3'd0;
      3'd1: r = 3'd3;
      3'd2: r = 3'd2;
      3'd3: r = 3'd4;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd6;
      3'd7: r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // clamp one divisor try to the ranges the chip supports
  function automatic logic [DIV_W-1:0] clamp_try(input logic [TRY_W-1:0] tryd,
                                                 input logic [TRY_W-1:0] base,
                                                 input logic             is_am);
    logic [TRY_W-1:0] t;
    logic [DIV_W-1:0] r;
    t = tryd + TRY_W'(am_round_up(tryd[2:0]));
    priority if (tryd <= TRY_W'(8)) begin
      r = DIV_W'(8);
    end else if (!is_am && tryd < TRY_W'(12)) begin
      r = DIV_W'(12);
    end else if (base < TRY_W'(16)) begin
      r = DIV_W'(16);
    end else if (is_am) begin
      r = (t > TRY_W'(AM_MAX_DIV)) ? AM_MAX_DIV : DIV_W'(t);
    end else begin
      r = (tryd > TRY_W'(BM_MAX_DIV)) ? BM_MAX_DIV : DIV_W'(tryd);
    end
    return r;
  endfunction

endpackage

@@ hdl/fractional_baud_divisor_encoder_core.sv @@
// fractional_baud_divisor_encoder_core: top level of the baud divisor encoder
// depends on fbd_pkg and fbd_div
//
// usage:
//   a request word (baud_rate_i) is taken at a clock edge with start_i high
//   and busy_o low; busy_o is always low, so one request per cycle
//   each result word appears on divisor_value_o, divisor_index_o,
//   achieved_rate_o and rate_error_o for exactly one cycle, marked by valid_o
//   pipeline stages, with NW = bits of REF_CLOCK_HZ:
//   NW stages of the base divider, one clamp stage, NW+1 stages of the two
//   rate dividers running side by side, one select and one encode stage
//   throughput: one word per cycle, set by the fully pipelined dividers
//   the receiver cannot stall; results leave in request order
//   configuration: cfg_we_i writes cfg_wdata_i into chip type (index 0) or
//   channel number (index 1); write only while no request is in flight
//   reset clears all in-flight valid bits and sets chip type 0, channel 1
`timescale 1ns / 1ps

module fractional_baud_divisor_encoder_core
  import fbd_pkg::*;
#(
  parameter int unsigned REF_CLOCK_HZ = REF_CLOCK_HZ_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [BAUD_W-1:0] baud_rate_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CHAN_W-1:0] cfg_wdata_i,
  output logic              valid_o,
  output logic [WORD_W-1:0] divisor_value_o,
  output logic [WORD_W-1:0] divisor_index_o,
  output logic [RATE_W-1:0] achieved_rate_o,
  output logic              rate_error_o
);

  localparam int unsigned NW = $clog2(REF_CLOCK_HZ + 1);
  localparam int unsigned EW = NW + 1;
  localparam int unsigned XW = (EW > BAUD_W) ? EW : BAUD_W;
  localparam logic [NW-1:0] REF_N  = NW'(REF_CLOCK_HZ);
  localparam logic [EW-1:0] REF_E  = EW'(REF_CLOCK_HZ);
  localparam int unsigned SW1 = BAUD_W + 1;
  localparam int unsigned SW2 = DIV_W + BAUD_W + 1;

  logic [CHIP_W-1:0] chip_type_q;
  logic [CHAN_W-1:0] channel_q;
  logic              is_am;
  logic              multi;

  assign busy_o = 1'b0;
  assign is_am  = (chip_type_q == CHIP_AM);
  assign multi  = (chip_type_q == CHIP_DUAL_C) || (chip_type_q == CHIP_DUAL_H) ||
                  (chip_type_q == CHIP_QUAD_H);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_type_q <= CHIP_AM;
      channel_q   <= CHAN_W'(1);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CHIP_TYPE: chip_type_q <= cfg_wdata_i[CHIP_W-1:0];
        REG_CHANNEL:   channel_q   <= cfg_wdata_i;
        default:       chip_type_q <= chip_type_q;
      endcase
    end
  end

  // base divisor: reference / baud
  logic              in_v;
  logic              d1_v;
  logic [NW-1:0]     d1_q;
  logic [SW1-1:0]    d1_side;

  assign in_v = start_i && !busy_o;

  fbd_div #(.NW(NW), .DW(BAUD_W), .SW(SW1)) u_div_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v),
    .num_i   (REF_N),
    .den_i   (baud_rate_i),
    .side_i  ({baud_rate_i, (baud_rate_i == '0)}),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .side_o  (d1_side)
  );

  // clamp stage
  logic [TRY_W-1:0]  base_w;
  logic [TRY_W-1:0]  try1_w;
  logic              c_v_q;
  logic [DIV_W-1:0]  c_try0_q;
  logic [DIV_W-1:0]  c_try1_q;
  logic [BAUD_W-1:0] c_baud_q;
  logic              c_zero_q;

  always_comb begin
    base_w = TRY_W'(d1_q);
    if (is_am) begin
      base_w = base_w - TRY_W'(am_round_down(d1_q[2:0]));
    end
    try1_w = base_w + TRY_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    c_try0_q <= clamp_try(base_w, base_w, is_am);
    c_try1_q <= clamp_try(try1_w, base_w, is_am);
    c_baud_q <= d1_side[SW1-1:1];
    c_zero_q <= d1_side[0];
  end

  // rate of each try: (reference + d/2) / d
  logic              d2_v;
  logic              d3_v;
  logic [EW-1:0]     est0;
  logic [EW-1:0]     est1;
  logic [SW2-1:0]    d2_side;
  logic [DIV_W-1:0]  d3_side;

  fbd_div #(.NW(EW), .DW(DIV_W), .SW(SW2)) u_div_try0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .num_i   (REF_E + EW'(c_try0_q >> 1)),
    .den_i   (c_try0_q),
    .side_i  ({c_try0_q, c_baud_q, c_zero_q}),
    .valid_o (d2_v),
    .quo_o   (est0),
    .side_o  (d2_side)
  );

  fbd_div #(.NW(EW), .DW(DIV_W), .SW(DIV_W)) u_div_try1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .num_i   (REF_E + EW'(c_try1_q >> 1)),
    .den_i   (c_try1_q),
    .side_i  (c_try1_q),
    .valid_o (d3_v),
    .quo_o   (est1),
    .side_o  (d3_side)
  );

  // select the nearest try, lower divisor on a tie
  logic [XW-1:0]     e0_x;
  logic [XW-1:0]     e1_x;
  logic [XW-1:0]     b_x;
  logic [XW-1:0]     diff0;
  logic [XW-1:0]     diff1;
  logic              take1;
  logic              s_v_q;
  logic [DIV_W-1:0]  s_div_q;
  logic [RATE_W-1:0] s_rate_q;
  logic              s_zero_q;

  always_comb begin
    e0_x  = XW'(est0);
    e1_x  = XW'(est1);
    b_x   = XW'(d2_side[BAUD_W:1]);
    diff0 = (e0_x < b_x) ? (b_x - e0_x) : (e0_x - b_x);
    diff1 = (e1_x < b_x) ? (b_x - e1_x) : (e1_x - b_x);
    take1 = (diff1 < diff0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= d2_v && d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s_div_q  <= take1 ? d3_side : d2_side[SW2-1:BAUD_W+1];
    s_rate_q <= take1 ? RATE_W'(est1) : RATE_W'(est0);
    s_zero_q <= d2_side[0];
  end

  // encode and split into value and index words
  logic [ENC_W-1:0]  enc_raw;
  logic [ENC_W-1:0]  enc;
  logic [WORD_W-1:0] idx;
  logic              o_v_q;

  always_comb begin
    enc_raw = {fraction_code(s_div_q[2:0]), s_div_q[DIV_W-1:3]};
    priority if (enc_raw == ENC_W'(1)) begin
      enc = '0;
    end else if (enc_raw == ENC_SPECIAL_2M) begin
      enc = ENC_W'(1);
    end else begin
      enc = enc_raw;
    end
    if (multi) begin
      idx = {7'd0, enc[ENC_W-1], channel_q};
    end else begin
      idx = WORD_W'(enc[ENC_W-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_value_o <= s_zero_q ? '0 : enc[WORD_W-1:0];
    divisor_index_o <= s_zero_q ? '0 : idx;
    achieved_rate_o <= s_zero_q ? '0 : s_rate_q;
    rate_error_o    <= s_zero_q;
  end

  assign valid_o = o_v_q;

endmodule

@@ hdl/fbd_div.sv @@
// fbd_div: pipelined restoring divider, one quotient bit per stage,
// with a sideband word that travels alongside; uses no package
`timescale 1ns / 1ps

module fbd_div #(
  parameter int unsigned NW = 25,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic          v_in    [NW];
  logic [DW-1:0] rem_in  [NW];
  logic [NW-1:0] num_in  [NW];
  logic [NW-1:0] quo_in  [NW];
  logic [DW-1:0] den_in  [NW];
  logic [SW-1:0] side_in [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] sh;
    logic        ge;
    logic [DW:0] diff;

    if (s == 0) begin : g_first
      assign v_in[s]    = valid_i;
      assign rem_in[s]  = '0;
      assign num_in[s]  = num_i;
      assign quo_in[s]  = '0;
      assign den_in[s]  = den_i;
      assign side_in[s] = side_i;
    end else begin : g_next
      assign v_in[s]    = v_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign num_in[s]  = num_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign side_in[s] = side_q[s-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      sh   = {rem_in[s], num_in[s][NW-1]};
      ge   = (sh >= {1'b0, den_in[s]});
      diff = sh - {1'b0, den_in[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
      num_q[s]  <= num_in[s] << 1;
      quo_q[s]  <= NW'({quo_in[s], ge});
      den_q[s]  <= den_in[s];
      side_q[s] <= side_in[s];
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

@@ hdl/fbd_chk.sv @@
// fbd_chk: port-level checks for fractional_baud_divisor_encoder_core
// depends on fbd_pkg; bound to the top level below
`timescale 1ns / 1ps

module fbd_chk
  import fbd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              valid_o,
  input logic [WORD_W-1:0] divisor_value_o,
  input logic [WORD_W-1:0] divisor_index_o,
  input logic [RATE_W-1:0] achieved_rate_o,
  input logic              rate_error_o
);

  // pipeline takes a word every cycle
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // error word carries all-zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rate_error_o |->
      divisor_value_o == '0 && divisor_index_o == '0 && achieved_rate_o == '0)
    else $error("error word with nonzero payload");

  // a good word always reaches some nonzero rate
  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !rate_error_o |-> achieved_rate_o != '0)
    else $error("zero achieved rate on good word");

  // nothing leaves in the first cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("word right after reset");

endmodule

bind fractional_baud_divisor_encoder_core fbd_chk u_fbd_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy_o          (busy_o),
  .valid_o         (valid_o),
  .divisor_value_o (divisor_value_o),
  .divisor_index_o (divisor_index_o),
  .achieved_rate_o (achieved_rate_o),
  .rate_error_o    (rate_error_o)
);

@@ bench/tb.sv @@
// tb: self-checking bench for fractional_baud_divisor_encoder_core
// predicts each divisor word in-bench and compares every result word in order; needs fbd_pkg
`timescale 1ns / 1ps

module tb;
  import fbd_pkg::*;

  localparam int unsigned REF_HZ = 24000000;
  localparam int unsigned SETTLE = 130;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] index;
    logic [RATE_W-1:0] rate;
    logic              err;
  } divisor_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [BAUD_W-1:0] baud_rate_i = '0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = REG_CHIP_TYPE;
  logic [CHAN_W-1:0] cfg_wdata_i = '0;
  logic              busy_o, valid_o, rate_error_o;
  logic [WORD_W-1:0] divisor_value_o, divisor_index_o;
  logic [RATE_W-1:0] achieved_rate_o;

  divisor_word_t     pending_words[$];
  logic [2:0]        chip_sel = 3'd0;
  logic [7:0]        chan_sel = 8'd1;
  int unsigned       n_sent = 0, n_checked = 0, n_errors = 0;

  logic [2:0] up_adj   [8] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd3, 3'd2, 3'd1};
  logic [2:0] down_adj [8] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3};
  logic [2:0] frac_enc [8] = '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7};

  logic [BAUD_W-1:0] test_rates_short[$] = '{1, 2000000, 3000000, 1500000, 24'hFFFFFF, 0};
  logic [CHAN_W-1:0] sweep_chips[$] = '{8'd5, 8'd2, 8'd4, 8'd1};

  fractional_baud_divisor_encoder_core i_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] fit_divisor(logic [63:0] d, logic [63:0] base, logic am);
    logic [63:0] r;
    r = d;
    if (d <= 8) begin
      r = 8;
    end else if (!am && d < 12) begin
      r = 12;
    end else if (base < 16) begin
      r = 16;
    end else if (am) begin
      r = d + up_adj[d[2:0]];
      if (r > 64'h1FFF8) r = 64'h1FFF8;
    end else if (d > 64'h1FFFF) begin
      r = 64'h1FFFF;
    end
    return r;
  endfunction

  function automatic divisor_word_t predict_divisor(logic [BAUD_W-1:0] baud);
    divisor_word_t w;
    logic          am, multi;
    logic [63:0]   base, d, est, diff, best_d, best_rate, best_diff, enc, idx;
    w = '0;
    if (baud == 0) begin
      w.err = 1'b1;
      return w;
    end
    am = (chip_sel == CHIP_AM);
    multi = (chip_sel == CHIP_DUAL_C || chip_sel == CHIP_DUAL_H || chip_sel == CHIP_QUAD_H);
    base = REF_HZ / baud;
    if (am) base = base - down_adj[base[2:0]];
    best_d = 0;
    best_rate = 0;
    best_diff = 0;
    for (int i = 0; i < 2; i++) begin
      d = fit_divisor(base + i, base, am);
      est = (REF_HZ + d / 2) / d;
      diff = (est < baud) ? baud - est : est - baud;
      if (i == 0 || diff < best_diff) begin
        best_d = d;
        best_rate = est;
        best_diff = diff;
        if (diff == 0) break;
      end
    end
    enc = (best_d >> 3) | (64'(frac_enc[best_d[2:0]]) << 14);
    if (enc == 1) enc = 0;
    else if (enc == 64'h4001) enc = 1;
    idx = multi ? (((enc >> 8) & 64'hFF00) | chan_sel) : (enc >> 16);
    w.value = enc[15:0];
    w.index = idx[15:0];
    w.rate = best_rate[21:0];
    return w;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    divisor_word_t want;
    if (rst_ni && valid_o) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", divisor_value_o, 0);
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (divisor_value_o !== want.value) report("divisor_value", divisor_value_o, want.value);
        if (divisor_index_o !== want.index) report("divisor_index", divisor_index_o, want.index);
        if (achieved_rate_o !== want.rate) report("achieved_rate", achieved_rate_o, want.rate);
        if (rate_error_o !== want.err) report("rate_error", rate_error_o, want.err);
      end
    end
  end

  // called right after a rising edge; leaves start high for back-to-back words
  task automatic send_word(logic [BAUD_W-1:0] baud);
    start_i <= 1'b1;
    baud_rate_i <= baud;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_words.push_back(predict_divisor(baud));
    n_sent++;
  endtask

  task automatic pause(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain;
    pause(1);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CHAN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_CHIP_TYPE) chip_sel = val[2:0];
    else chan_sel = val;
  endtask

  function automatic logic [BAUD_W-1:0] random_baud;
    logic [BAUD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 3) == 0 ? '0 : BAUD_W'($urandom());
      1, 2:    v = BAUD_W'(REF_HZ / $urandom_range(8, 32'h1FFFF));
      3:       v = BAUD_W'($urandom_range(1, 40));
      default: v = BAUD_W'($urandom_range(1, 1 << $urandom_range(4, 22)));
    endcase
    return v;
  endfunction

  task automatic random_run(int unsigned n_words);
    int unsigned left, burst;
    left = n_words;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int unsigned k = 0; k < burst && left > 0; k++, left--) send_word(random_baud());
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 9));
    end
  endtask

  // reset values: am type, channel 1; extremes and the encoding special case for divisor 8
  task automatic test_directed;
    logic [BAUD_W-1:0] rates[$] = '{0, 1, 2, 183, 184, 300, 9600, 115200, 1000000, 1500000,
                                   2000000, 2400000, 3000000, 4000000, 6000000, 12000000,
                                   16000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 1846153};
    foreach (rates[k]) send_word(rates[k]);
    drain();
  endtask

  task automatic test_chip_types;
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_CHIP_TYPE, CHAN_W'(c));
      write_reg(REG_CHANNEL, (c == 2) ? 8'h00 : (c == 4) ? 8'hFF : CHAN_W'($urandom()));
      foreach (test_rates_short[k]) send_word(test_rates_short[k]);
      random_run(65);
      drain();
    end
  endtask

  task automatic test_channel_sweep;
    foreach (sweep_chips[k]) begin
      write_reg(REG_CHIP_TYPE, sweep_chips[k]);
      write_reg(REG_CHANNEL, CHAN_W'($urandom()));
      random_run(30);
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_chip_types();
    test_channel_sweep();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d request words over all eight chip type codes, %0d results checked",
             n_sent, n_checked);
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ fractional_baud_divisor_encoder_core.f @@
hdl/fbd_pkg.sv
hdl/fbd_div.sv
hdl/fractional_baud_divisor_encoder_core.sv
hdl/fbd_chk.sv
bench/tb.sv
